// ===== src/bsdo_pkg.sv =====
// shared types and constants for the bounded drop-oldest stack
package bsdo_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_W    = 8;

	typedef enum logic [1:0] {
		REQ_PUSH  = 2'd0,
		REQ_POP   = 2'd1,
		REQ_FORCE = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_DROPPED = 2'd3
	} status_t;

	typedef struct packed {
		logic    pop_ok;
		status_t status;
		logic    is_empty;
		logic    is_full;
	} res_t;

endpackage

// ===== src/bounded_stack_drop_oldest.sv =====
// top level of the bounded byte stack that drops its oldest element
//
// a request (req_type, push_value) transfers at a rising edge with start high
// and busy low. busy stays low: the ring pointers let every request finish
// its single store access in the cycle it is taken, so one request can be
// sent every cycle.
// each request gives exactly one result, in the cycle after its transfer: done
// is high for one cycle with pop_value, status, is_empty and is_full. the
// receiver cannot stall, so results must be taken in that cycle.
// push writes the next free slot, pop reads the top slot through the
// registered store read port, force push on a full stack overwrites the bottom
// slot and moves the bottom pointer. push on full and pop on empty leave the
// stack unchanged and report their status; code 3 does nothing.
// pop_value is zero unless the request was a successful pop.
// reset (arst_n low) empties the stack at once; the store itself is not
// cleared and needs no clearing pass.
module bounded_stack_drop_oldest #(
	parameter int DEPTH = bsdo_pkg::DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  req_type,
	input  logic [bsdo_pkg::DATA_W-1:0] push_value,
	output logic                        done,
	output logic [bsdo_pkg::DATA_W-1:0] pop_value,
	output logic [1:0]                  status,
	output logic                        is_empty,
	output logic                        is_full
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic                        accept;
	logic                        wr_en;
	logic [AW-1:0]               wr_addr;
	logic [bsdo_pkg::DATA_W-1:0] wr_data;
	logic                        rd_en;
	logic [AW-1:0]               rd_addr;
	logic [bsdo_pkg::DATA_W-1:0] rd_data;
	logic                        done_s1;
	bsdo_pkg::res_t              res_s1;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	bsdo_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.req_type   (req_type),
		.push_value (push_value),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.done_s1    (done_s1),
		.res_s1     (res_s1)
	);

	bsdo_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign done      = done_s1;
	assign pop_value = res_s1.pop_ok ? rd_data : '0;
	assign status    = res_s1.status;
	assign is_empty  = res_s1.is_empty;
	assign is_full   = res_s1.is_full;

endmodule

// ===== src/bsdo_mem.sv =====
// element store: one write port, one registered read port
module bsdo_mem #(
	parameter int DEPTH = bsdo_pkg::DEPTH_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [bsdo_pkg::DATA_W-1:0] wr_data,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	output logic [bsdo_pkg::DATA_W-1:0] rd_data
);

	logic [bsdo_pkg::DATA_W-1:0] mem [DEPTH];
	logic [bsdo_pkg::DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/bsdo_ctrl.sv =====
// ring pointers, element count and per-request status for the stack
module bsdo_ctrl #(
	parameter int DEPTH = bsdo_pkg::DEPTH_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [1:0]                  req_type,
	input  logic [bsdo_pkg::DATA_W-1:0] push_value,
	output logic                        wr_en,
	output logic [AW-1:0]               wr_addr,
	output logic [bsdo_pkg::DATA_W-1:0] wr_data,
	output logic                        rd_en,
	output logic [AW-1:0]               rd_addr,
	output logic                        done_s1,
	output bsdo_pkg::res_t              res_s1
);

	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

	logic [AW-1:0]  bottom_q;
	logic [AW-1:0]  top_q;
	logic [CW-1:0]  count_q;
	logic [AW-1:0]  bottom_nxt;
	logic [AW-1:0]  top_nxt;
	logic [CW-1:0]  count_nxt;
	logic [AW-1:0]  top_inc;
	logic [AW-1:0]  top_dec;
	logic [AW-1:0]  bottom_inc;
	logic           full;
	logic           empty;
	bsdo_pkg::req_t req;
	bsdo_pkg::res_t res;

	assign req        = bsdo_pkg::req_t'(req_type);
	assign full       = (count_q == FULL_CNT);
	assign empty      = (count_q == '0);
	assign top_inc    = (top_q == LAST_SLOT) ? '0 : top_q + AW'(1);
	assign top_dec    = (top_q == '0) ? LAST_SLOT : top_q - AW'(1);
	assign bottom_inc = (bottom_q == LAST_SLOT) ? '0 : bottom_q + AW'(1);

	// top_q is the next free slot; on a full stack it equals the bottom slot
	always_comb begin
		bottom_nxt   = bottom_q;
		top_nxt      = top_q;
		count_nxt    = count_q;
		wr_en        = 1'b0;
		rd_en        = 1'b0;
		wr_addr      = top_q;
		wr_data      = push_value;
		rd_addr      = top_dec;
		res.pop_ok   = 1'b0;
		res.status   = bsdo_pkg::ST_OK;
		case (req)
			bsdo_pkg::REQ_PUSH: begin
				if (full) begin
					res.status = bsdo_pkg::ST_FULL;
				end else begin
					wr_en     = accept;
					top_nxt   = top_inc;
					count_nxt = count_q + CW'(1);
				end
			end
			bsdo_pkg::REQ_POP: begin
				if (empty) begin
					res.status = bsdo_pkg::ST_EMPTY;
				end else begin
					rd_en      = accept;
					res.pop_ok = 1'b1;
					top_nxt    = top_dec;
					count_nxt  = count_q - CW'(1);
				end
			end
			bsdo_pkg::REQ_FORCE: begin
				wr_en   = accept;
				top_nxt = top_inc;
				if (full) begin
					res.status = bsdo_pkg::ST_DROPPED;
					bottom_nxt = bottom_inc;
				end else begin
					count_nxt = count_q + CW'(1);
				end
			end
			default: begin
			end
		endcase
		res.is_empty = (count_nxt == '0);
		res.is_full  = (count_nxt == FULL_CNT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bottom_q <= '0;
			top_q    <= '0;
			count_q  <= '0;
			done_s1  <= 1'b0;
		end else begin
			done_s1 <= accept;
			if (accept) begin
				bottom_q <= bottom_nxt;
				top_q    <= top_nxt;
				count_q  <= count_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	// next free slot (top_q) stays bottom + count around the ring
	logic [AW:0] ring_sum;
	logic [AW:0] ring_top;
	assign ring_sum = {1'b0, bottom_q} + (AW+1)'(count_q);
	assign ring_top = (ring_sum >= (AW+1)'(DEPTH)) ? ring_sum - (AW+1)'(DEPTH) : ring_sum;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("count beyond depth");

	a_ring_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		ring_top == {1'b0, top_q})
		else $error("top pointer out of step with bottom and count");

	a_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("read and write in the same request");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req == bsdo_pkg::REQ_PUSH && !full |=> count_q == $past(count_q) + CW'(1))
		else $error("push did not grow the stack");

	a_drop_keeps_full: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req == bsdo_pkg::REQ_FORCE && full |=> full && bottom_q != $past(bottom_q))
		else $error("force push on full did not advance bottom");

endmodule
